>>> hw/rtl/fftpm_pkg.sv
package fftpm_pkg;

  // Block configuration.
  localparam int MAX_LEN   = 32;
  localparam int FFT_SIZE  = 64;
  localparam int COEF_BITS = 12;
  localparam int FRAC_BITS = 16;
  localparam int TW_BITS   = 16;

  // Storage geometry: the twiddle table has 64 points, so every store has 64 entries.
  localparam int AW           = 6;
  localparam int DEPTH        = 64;
  localparam int DW           = 56;
  localparam int HW           = DW / 2;
  localparam int WW           = 2 * DW;
  localparam int OUT_W        = 29;
  localparam int RMAG_W       = DW - FRAC_BITS + 1;
  localparam int ACCEPT_LIMIT = (MAX_LEN < FFT_SIZE / 2) ? MAX_LEN : FFT_SIZE / 2;

  typedef logic [AW-1:0]            addr_t;
  typedef logic signed [DW-1:0]     word_t;
  typedef logic [WW-1:0]            entry_t;
  typedef logic [RMAG_W-1:0]        rmag_t;
  typedef logic signed [OUT_W-1:0]  coef_t;

  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Channel payloads.
  typedef struct packed {
    logic               req_type;
    logic signed [11:0] coefficient;
    logic               last_coef;
  } coef_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] product_coef;
    logic [5:0]              degree;
    logic                    last_out;
    logic                    dropped;
  } prod_item_t;

  // Handshake between the sequencer and the shared multiplier.
  typedef struct packed {
    logic start;
    logic frac_mode;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    word_t result;
  } mul_rsp_t;

  // Status from the core to the channel logic.
  typedef struct packed {
    logic busy;
    logic res_valid;
  } core_stat_t;

  // First quadrant of cos(2*pi*k/64) in Q1.16.
  localparam logic [16:0] COS_Q [17] = '{
    17'd65536, 17'd65220, 17'd64277, 17'd62714, 17'd60547, 17'd57798,
    17'd54491, 17'd50660, 17'd46341, 17'd41576, 17'd36410, 17'd30893,
    17'd25080, 17'd19024, 17'd12785, 17'd6424,  17'd0
  };

  function automatic logic signed [17:0] cos64(input addr_t k);
    logic signed [17:0] v;
    if (k <= 6'd16) begin
      v = signed'({1'b0, COS_Q[k[4:0]]});
    end else if (k <= 6'd32) begin
      v = -signed'({1'b0, COS_Q[5'(6'd32 - k)]});
    end else if (k <= 6'd48) begin
      v = -signed'({1'b0, COS_Q[5'(k - 6'd32)]});
    end else begin
      v = signed'({1'b0, COS_Q[5'(7'd64 - {1'b0, k})]});
    end
    return v;
  endfunction

  // Reverse the low lg bits of i.
  function automatic addr_t bitrev(input addr_t i, input logic [2:0] lg);
    addr_t r;
    for (int b = 0; b < AW; b++) begin
      r[b] = i[AW-1-b];
    end
    return r >> (3'(AW) - lg);
  endfunction

  // Smallest lg with 2^lg >= n.
  function automatic logic [2:0] ceil_log2(input addr_t n);
    logic [2:0] lg;
    lg = 3'd0;
    for (int s = 0; s < AW; s++) begin
      if ((7'd1 << lg) < {1'b0, n}) begin
        lg = lg + 3'd1;
      end
    end
    return lg;
  endfunction

endpackage

>>> hw/rtl/fftpm_mul.sv
module fftpm_mul (
  input  logic               clk,
  input  logic               rst,
  input  fftpm_pkg::mul_req_t req,
  input  fftpm_pkg::word_t   a,
  input  fftpm_pkg::word_t   b,
  output fftpm_pkg::mul_rsp_t rsp
);

  typedef logic [fftpm_pkg::DW-1:0]   mag_t;
  typedef logic [fftpm_pkg::HW-1:0]   half_t;
  typedef logic [2*fftpm_pkg::HW-1:0] pp_t;
  typedef logic [2*fftpm_pkg::DW-1:0] acc_t;

  mag_t       ma;
  mag_t       mb;
  logic       neg;
  logic       frac;
  logic       busy;
  logic [2:0] cnt;
  pp_t        pp;
  logic [1:0] pp_sh;
  acc_t       acc;
  half_t      a_part;
  half_t      b_part;
  acc_t       rnd;

  // Partial product order: low*low, low*high, high*low, high*high.
  assign a_part = cnt[1] ? ma[fftpm_pkg::DW-1:fftpm_pkg::HW] : ma[fftpm_pkg::HW-1:0];
  assign b_part = cnt[0] ? mb[fftpm_pkg::DW-1:fftpm_pkg::HW] : mb[fftpm_pkg::HW-1:0];

  // Round half away from zero on the magnitude.
  always_comb begin
    if (frac) begin
      rnd = (acc + (acc_t'(1) << (fftpm_pkg::FRAC_BITS - 1))) >> fftpm_pkg::FRAC_BITS;
    end else begin
      rnd = (acc + (acc_t'(1) << (fftpm_pkg::TW_BITS - 1))) >> fftpm_pkg::TW_BITS;
    end
  end

  // Sequence the four partial products through one multiplier.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= 3'd0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        ma   <= a[fftpm_pkg::DW-1] ? mag_t'(-a) : mag_t'(a);
        mb   <= b[fftpm_pkg::DW-1] ? mag_t'(-b) : mag_t'(b);
        neg  <= a[fftpm_pkg::DW-1] ^ b[fftpm_pkg::DW-1];
        frac <= req.frac_mode;
        acc  <= '0;
        cnt  <= 3'd0;
        busy <= 1'b1;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt <= 3'd3) begin
          pp    <= pp_t'(a_part) * pp_t'(b_part);
          pp_sh <= 2'(cnt[1]) + 2'(cnt[0]);
        end
        if (cnt >= 3'd1 && cnt <= 3'd4) begin
          acc <= acc + (acc_t'(pp) << (fftpm_pkg::HW * pp_sh));
        end
        if (cnt == 3'd5) begin
          busy       <= 1'b0;
          rsp.done   <= 1'b1;
          rsp.result <= neg ? -fftpm_pkg::word_t'(rnd[fftpm_pkg::DW-1:0])
                            : fftpm_pkg::word_t'(rnd[fftpm_pkg::DW-1:0]);
        end
      end
    end
  end

endmodule

>>> hw/rtl/fftpm_core.sv
module fftpm_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  fftpm_pkg::coef_item_t   item,
  input  logic                    res_take,
  output fftpm_pkg::core_stat_t   stat,
  output fftpm_pkg::prod_item_t   res
);

  typedef enum logic [20:0] {
    S_LOAD   = 21'd1 << 0,
    S_SIZE   = 21'd1 << 1,
    S_REV0   = 21'd1 << 2,
    S_REV1   = 21'd1 << 3,
    S_REV2   = 21'd1 << 4,
    S_REV3   = 21'd1 << 5,
    S_BF0    = 21'd1 << 6,
    S_BF1    = 21'd1 << 7,
    S_BF2    = 21'd1 << 8,
    S_MSTART = 21'd1 << 9,
    S_MWAIT  = 21'd1 << 10,
    S_BF3    = 21'd1 << 11,
    S_BF4    = 21'd1 << 12,
    S_XDONE  = 21'd1 << 13,
    S_PW0    = 21'd1 << 14,
    S_PW1    = 21'd1 << 15,
    S_PW3    = 21'd1 << 16,
    S_OUT0   = 21'd1 << 17,
    S_OUT1   = 21'd1 << 18,
    S_OUT2   = 21'd1 << 19,
    S_CLEAR  = 21'd1 << 20
  } state_t;

  localparam logic [1:0] PASS_A   = 2'd0;
  localparam logic [1:0] PASS_B   = 2'd1;
  localparam logic [1:0] PASS_INV = 2'd2;

  state_t                state;
  logic [1:0]            pass;
  fftpm_pkg::addr_t      count_a;
  fftpm_pkg::addr_t      count_b;
  logic                  overflow_seen;
  fftpm_pkg::addr_t      n_m1;
  logic [2:0]            lg;
  fftpm_pkg::addr_t      idx;
  logic [2:0]            stage;
  logic [1:0]            op;
  logic                  pw_mode;
  fftpm_pkg::word_t      p_re, p_im, x_re, x_im, y_re, y_im;
  fftpm_pkg::word_t      m_q [4];
  fftpm_pkg::rmag_t      rnd_mag;
  logic                  rnd_neg;

  // Data stores: real part in the upper half of each entry.
  fftpm_pkg::entry_t     mem_a [fftpm_pkg::DEPTH];
  fftpm_pkg::entry_t     mem_b [fftpm_pkg::DEPTH];
  logic [fftpm_pkg::DEPTH-1:0] val_a;
  logic [fftpm_pkg::DEPTH-1:0] val_b;
  fftpm_pkg::entry_t     rd_a, rd_b;
  logic                  rdv_a, rdv_b;

  fftpm_pkg::addr_t      rd_addr, wr_addr;
  fftpm_pkg::entry_t     wr_data;
  logic                  we_a, we_b;
  fftpm_pkg::entry_t     data_a, data_b, cur;
  fftpm_pkg::word_t      cur_re, cur_im, a_re, tr, ti;
  fftpm_pkg::addr_t      size_m1, half, j_idx, p_addr, q_addr, tw_k, rev;
  fftpm_pkg::word_t      load_val;
  logic signed [fftpm_pkg::COEF_BITS-1:0] coef_lo;
  logic                  xform_pass;
  fftpm_pkg::mul_req_t   mul_req;
  fftpm_pkg::mul_rsp_t   mul_rsp;
  fftpm_pkg::word_t      mul_a, mul_b;
  logic [6:0]            la, lb;
  logic [5:0]            rsh;
  fftpm_pkg::word_t      mag_src;
  logic [fftpm_pkg::DW-1:0] out_mag;
  fftpm_pkg::coef_t      coef_sat;

  fftpm_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .a   (mul_a),
    .b   (mul_b),
    .rsp (mul_rsp)
  );

  // Addressing for bit reversal and butterflies.
  always_comb begin
    size_m1 = fftpm_pkg::addr_t'((7'd1 << lg) - 7'd1);
    half    = fftpm_pkg::addr_t'(7'd1 << (stage - 3'd1));
    j_idx   = idx & (half - 6'd1);
    p_addr  = fftpm_pkg::addr_t'((idx >> (stage - 3'd1)) << stage) | j_idx;
    q_addr  = p_addr | half;
    tw_k    = fftpm_pkg::addr_t'(j_idx << (3'(fftpm_pkg::AW) - stage));
    rev     = fftpm_pkg::bitrev(idx, lg);
  end

  // Read data, with unwritten entries reading as zero.
  always_comb begin
    data_a = rdv_a ? rd_a : '0;
    data_b = rdv_b ? rd_b : '0;
    cur    = (pass == PASS_B) ? data_b : data_a;
    cur_re = fftpm_pkg::word_t'(cur[fftpm_pkg::WW-1:fftpm_pkg::DW]);
    cur_im = fftpm_pkg::word_t'(cur[fftpm_pkg::DW-1:0]);
    a_re   = fftpm_pkg::word_t'(data_a[fftpm_pkg::WW-1:fftpm_pkg::DW]);
    tr     = m_q[0] - m_q[1];
    ti     = m_q[2] + m_q[3];
  end

  // Incoming coefficient in Q.FRAC_BITS.
  always_comb begin
    coef_lo  = item.coefficient[fftpm_pkg::COEF_BITS-1:0];
    load_val = fftpm_pkg::word_t'(coef_lo) <<< fftpm_pkg::FRAC_BITS;
  end

  // Operand selection for the four real products of a complex product.
  always_comb begin
    mul_a             = op[0] ? x_im : x_re;
    mul_b             = (op[0] ^ op[1]) ? y_im : y_re;
    mul_req.start     = (state == S_MSTART);
    mul_req.frac_mode = pw_mode;
  end

  // Memory port control.
  always_comb begin
    xform_pass = (pass == PASS_B);
    rd_addr    = idx;
    wr_addr    = idx;
    wr_data    = '0;
    we_a       = 1'b0;
    we_b       = 1'b0;
    case (state)
      S_LOAD: begin
        if (load) begin
          if (!item.req_type) begin
            wr_addr = count_a;
            wr_data = {load_val, fftpm_pkg::word_t'(0)};
            we_a    = (count_a < fftpm_pkg::addr_t'(fftpm_pkg::ACCEPT_LIMIT));
          end else begin
            wr_addr = count_b;
            wr_data = {load_val, fftpm_pkg::word_t'(0)};
            we_b    = (count_b < fftpm_pkg::addr_t'(fftpm_pkg::ACCEPT_LIMIT));
          end
        end
      end
      S_REV1: rd_addr = rev;
      S_REV2: begin
        wr_addr = idx;
        wr_data = cur;
        we_a    = !xform_pass;
        we_b    = xform_pass;
      end
      S_REV3: begin
        wr_addr = rev;
        wr_data = {p_re, p_im};
        we_a    = !xform_pass;
        we_b    = xform_pass;
      end
      S_BF0: rd_addr = p_addr;
      S_BF1: rd_addr = q_addr;
      S_BF3: begin
        wr_addr = p_addr;
        wr_data = {p_re + tr, p_im + ti};
        we_a    = !xform_pass;
        we_b    = xform_pass;
      end
      S_BF4: begin
        wr_addr = q_addr;
        wr_data = {p_re - tr, p_im - ti};
        we_a    = !xform_pass;
        we_b    = xform_pass;
      end
      S_PW3: begin
        wr_addr = idx;
        wr_data = {tr, -ti};
        we_a    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Store arrays with registered reads.
  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wr_addr] <= wr_data;
    end
    if (we_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    rd_a  <= mem_a[rd_addr];
    rd_b  <= mem_b[rd_addr];
    rdv_a <= val_a[rd_addr];
    rdv_b <= val_b[rd_addr];
  end

  // Written-entry flags; clearing them empties the stores.
  always_ff @(posedge clk) begin
    if (rst || state == S_CLEAR) begin
      val_a <= '0;
      val_b <= '0;
    end else begin
      if (we_a) begin
        val_a[wr_addr] <= 1'b1;
      end
      if (we_b) begin
        val_b[wr_addr] <= 1'b1;
      end
    end
  end

  // Product length, with an empty polynomial taken as one zero coefficient.
  always_comb begin
    la = (count_a == '0) ? 7'd1 : {1'b0, count_a};
    lb = (count_b == '0) ? 7'd1 : {1'b0, count_b};
  end

  // Final scaling by size and 2^FRAC_BITS.
  always_comb begin
    rsh     = 6'(lg) + 6'(fftpm_pkg::FRAC_BITS);
    mag_src = a_re[fftpm_pkg::DW-1] ? -a_re : a_re;
    out_mag = (fftpm_pkg::DW)'(mag_src);
    if (!rnd_neg) begin
      coef_sat = (rnd_mag > fftpm_pkg::rmag_t'(fftpm_pkg::OUT_MAX))
               ? fftpm_pkg::coef_t'(fftpm_pkg::OUT_MAX) : fftpm_pkg::coef_t'(rnd_mag);
    end else begin
      coef_sat = (rnd_mag >= fftpm_pkg::rmag_t'(fftpm_pkg::OUT_MIN))
               ? fftpm_pkg::coef_t'(fftpm_pkg::OUT_MIN) : -fftpm_pkg::coef_t'(rnd_mag);
    end
    res.product_coef = coef_sat;
    res.degree       = idx;
    res.last_out     = (idx == n_m1);
    res.dropped      = overflow_seen;
    stat.busy        = (state != S_LOAD);
    stat.res_valid   = (state == S_OUT2);
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      pass          <= PASS_A;
      count_a       <= '0;
      count_b       <= '0;
      overflow_seen <= 1'b0;
      idx           <= '0;
      stage         <= 3'd1;
      op            <= 2'd0;
      pw_mode       <= 1'b0;
      lg            <= 3'd0;
      n_m1          <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (load) begin
            if (!item.req_type) begin
              if (count_a < fftpm_pkg::addr_t'(fftpm_pkg::ACCEPT_LIMIT)) begin
                count_a <= count_a + 6'd1;
              end else begin
                overflow_seen <= 1'b1;
              end
            end else begin
              if (count_b < fftpm_pkg::addr_t'(fftpm_pkg::ACCEPT_LIMIT)) begin
                count_b <= count_b + 6'd1;
              end else begin
                overflow_seen <= 1'b1;
              end
              if (item.last_coef) begin
                state <= S_SIZE;
              end
            end
          end
        end
        S_SIZE: begin
          n_m1  <= fftpm_pkg::addr_t'(la + lb - 7'd2);
          lg    <= fftpm_pkg::ceil_log2(fftpm_pkg::addr_t'(la + lb - 7'd1));
          pass  <= PASS_A;
          idx   <= '0;
          state <= S_REV0;
        end
        S_REV0: begin
          if (rev > idx) begin
            state <= S_REV1;
          end else if (idx == size_m1) begin
            idx   <= '0;
            stage <= 3'd1;
            state <= (lg == 3'd0) ? S_XDONE : S_BF0;
          end else begin
            idx <= idx + 6'd1;
          end
        end
        S_REV1: begin
          p_re  <= cur_re;
          p_im  <= cur_im;
          state <= S_REV2;
        end
        S_REV2: state <= S_REV3;
        S_REV3: begin
          if (idx == size_m1) begin
            idx   <= '0;
            stage <= 3'd1;
            state <= (lg == 3'd0) ? S_XDONE : S_BF0;
          end else begin
            idx   <= idx + 6'd1;
            state <= S_REV0;
          end
        end
        S_BF0: state <= S_BF1;
        S_BF1: begin
          p_re  <= cur_re;
          p_im  <= cur_im;
          state <= S_BF2;
        end
        S_BF2: begin
          x_re    <= cur_re;
          x_im    <= cur_im;
          y_re    <= fftpm_pkg::word_t'(fftpm_pkg::cos64(tw_k));
          y_im    <= fftpm_pkg::word_t'(fftpm_pkg::cos64(tw_k + 6'd48));
          op      <= 2'd0;
          pw_mode <= 1'b0;
          state   <= S_MSTART;
        end
        S_MSTART: state <= S_MWAIT;
        S_MWAIT: begin
          if (mul_rsp.done) begin
            m_q[op] <= mul_rsp.result;
            if (op == 2'd3) begin
              state <= pw_mode ? S_PW3 : S_BF3;
            end else begin
              op    <= op + 2'd1;
              state <= S_MSTART;
            end
          end
        end
        S_BF3: state <= S_BF4;
        S_BF4: begin
          if (idx == (size_m1 >> 1)) begin
            idx <= '0;
            if (stage == lg) begin
              state <= S_XDONE;
            end else begin
              stage <= stage + 3'd1;
              state <= S_BF0;
            end
          end else begin
            idx   <= idx + 6'd1;
            state <= S_BF0;
          end
        end
        S_XDONE: begin
          idx <= '0;
          case (pass)
            PASS_A: begin
              pass  <= PASS_B;
              state <= S_REV0;
            end
            PASS_B:  state <= S_PW0;
            default: state <= S_OUT0;
          endcase
        end
        S_PW0: state <= S_PW1;
        S_PW1: begin
          x_re    <= fftpm_pkg::word_t'(data_a[fftpm_pkg::WW-1:fftpm_pkg::DW]);
          x_im    <= fftpm_pkg::word_t'(data_a[fftpm_pkg::DW-1:0]);
          y_re    <= fftpm_pkg::word_t'(data_b[fftpm_pkg::WW-1:fftpm_pkg::DW]);
          y_im    <= fftpm_pkg::word_t'(data_b[fftpm_pkg::DW-1:0]);
          op      <= 2'd0;
          pw_mode <= 1'b1;
          state   <= S_MSTART;
        end
        S_PW3: begin
          if (idx == size_m1) begin
            idx   <= '0;
            pass  <= PASS_INV;
            state <= S_REV0;
          end else begin
            idx   <= idx + 6'd1;
            state <= S_PW0;
          end
        end
        S_OUT0: state <= S_OUT1;
        S_OUT1: begin
          rnd_neg <= a_re[fftpm_pkg::DW-1];
          rnd_mag <= fftpm_pkg::rmag_t'((out_mag >> rsh)
                     + (fftpm_pkg::DW)'(out_mag[rsh - 6'd1]));
          state   <= S_OUT2;
        end
        S_OUT2: begin
          if (res_take) begin
            if (idx == n_m1) begin
              state <= S_CLEAR;
            end else begin
              idx   <= idx + 6'd1;
              state <= S_OUT0;
            end
          end
        end
        S_CLEAR: begin
          count_a       <= '0;
          count_b       <= '0;
          overflow_seen <= 1'b0;
          pass          <= PASS_A;
          state         <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

>>> hw/rtl/fft_polynomial_multiplier.sv
// Polynomial multiplier built on a fixed-point radix-2 FFT.
// Input channel (coef_valid / coef_stall / coef_item): coefficients of A, then
// of B, lowest degree first, one transfer per cycle while loading. The transfer
// that carries the last B coefficient starts the product; coef_stall stays high
// until every product coefficient has been handed to the output register.
// Output channel (prod_valid / prod_stall / prod_item): lenA+lenB-1 transfers,
// lowest degree first, last_out set on the highest degree.
// Compute: each 56x56 multiply runs as four 28x28 partial products on one multiplier,
// shared by the butterflies and the pointwise products. That multiplier and the
// stores, each with one read and one write port, bound the compute time.
// Reset empties both stores, clears the counters and the dropped flag, and
// leaves the block ready to load. When the receiver stalls, the finished
// coefficient waits in the output register and the sequencer holds the next one.
module fft_polynomial_multiplier (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  coef_valid,
  output logic                  coef_stall,
  input  fftpm_pkg::coef_item_t coef_item,
  output logic                  prod_valid,
  input  logic                  prod_stall,
  output fftpm_pkg::prod_item_t prod_item
);

  fftpm_pkg::core_stat_t stat;
  fftpm_pkg::prod_item_t res;
  logic                  res_take;
  logic                  load;

  assign coef_stall = stat.busy;
  assign load       = coef_valid && !coef_stall;
  assign res_take   = !prod_valid || !prod_stall;

  fftpm_core u_core (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .item     (coef_item),
    .res_take (res_take),
    .stat     (stat),
    .res      (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (stat.res_valid && res_take) begin
      prod_valid <= 1'b1;
    end else if (!prod_stall) begin
      prod_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.res_valid && res_take) begin
      prod_item <= res;
    end
  end

  // A last B coefficient locks out further input.
  assert property (@(posedge clk) disable iff (rst)
    load && coef_item.req_type && coef_item.last_coef |=> coef_stall)
    else $error("input not stalled after the last B coefficient");

  // A pending result is held until the output register takes it.
  assert property (@(posedge clk) disable iff (rst)
    stat.res_valid && !res_take |=> stat.res_valid && $stable(res))
    else $error("pending result changed before transfer");

  // Results only come while the core is busy.
  assert property (@(posedge clk) disable iff (rst)
    !stat.busy |-> !stat.res_valid)
    else $error("result offered while idle");

endmodule
